FILE: rtl/core/bfu_pkg.sv
// ----------------------------------------------------------------------------
// bfu_pkg
// Shared constants, codes, types and helpers of the bounded field unpacker.
// ----------------------------------------------------------------------------
package bfu_pkg;

	localparam int MESSAGE_BYTES = 1024;
	localparam int ADDR_W        = $clog2(MESSAGE_BYTES);
	localparam int LEN_W         = $clog2(MESSAGE_BYTES + 1);
	localparam int POS_W         = LEN_W + 3;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_SHORT  = 2'd1;
	localparam logic [1:0] ST_ABOVE  = 2'd2;
	localparam logic [1:0] ST_BOUNDS = 2'd3;

	localparam logic [1:0] WC_8  = 2'd0;
	localparam logic [1:0] WC_16 = 2'd1;
	localparam logic [1:0] WC_32 = 2'd2;

	// bounds result handed from the range pipeline to the sequencer
	typedef struct packed {
		logic        valid;
		logic        zero;
		logic [6:0]  nb;
		logic [63:0] range;
		logic [63:0] lo;
		logic [1:0]  wc;
	} bnd_t;

	function automatic logic [63:0] width_mask(input logic [1:0] wc);
		logic [63:0] m;
		case (wc)
			WC_8:    m = 64'h0000_0000_0000_00FF;
			WC_16:   m = 64'h0000_0000_0000_FFFF;
			WC_32:   m = 64'h0000_0000_FFFF_FFFF;
			default: m = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		return m;
	endfunction

	// index of the highest set bit of a byte (0 when the byte is zero)
	function automatic logic [2:0] lane_msb(input logic [7:0] b);
		logic [2:0] idx;
		idx = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				idx = 3'(i);
			end
		end
		return idx;
	endfunction

endpackage

FILE: rtl/core/bfu_msg_store.sv
// ----------------------------------------------------------------------------
// bfu_msg_store
// Byte-wide message memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bfu_msg_store (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [bfu_pkg::ADDR_W-1:0] wr_addr,
	input  logic [7:0]                wr_data,
	input  logic                      rd_en,
	input  logic [bfu_pkg::ADDR_W-1:0] rd_addr,
	output logic [7:0]                rd_data
);

	logic [7:0] mem_q [bfu_pkg::MESSAGE_BYTES];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/core/bfu_bound_calc.sv
// ----------------------------------------------------------------------------
// bfu_bound_calc
// Three-stage pipeline: masked range, per-byte bit length, field bit count.
// ----------------------------------------------------------------------------
module bfu_bound_calc (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [63:0]   min_value,
	input  logic [63:0]   max_value,
	input  logic [1:0]    width_code,
	output bfu_pkg::bnd_t bnd
);

	logic        v_s1, v_s2, v_s3;
	logic [63:0] range_s1, range_s2, range_s3;
	logic [63:0] lo_s1, lo_s2, lo_s3;
	logic [1:0]  wc_s1, wc_s2, wc_s3;
	logic [7:0]  nz_s2;
	logic [2:0]  msb_s2 [8];
	logic        zero_s3;
	logic [6:0]  nb_s3;
	logic        zero_c;
	logic [6:0]  nb_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// top nonzero byte lane sets the bit count
	always_comb begin
		zero_c = 1'b1;
		nb_c   = 7'd0;
		for (int i = 0; i < 8; i++) begin
			if (nz_s2[i]) begin
				zero_c = 1'b0;
				nb_c   = {1'b0, 3'(i), 3'b000} + {4'b0000, msb_s2[i]} + 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			range_s1 <= (max_value - min_value) & bfu_pkg::width_mask(width_code);
			lo_s1    <= min_value & bfu_pkg::width_mask(width_code);
			wc_s1    <= width_code;
		end
		range_s2 <= range_s1;
		lo_s2    <= lo_s1;
		wc_s2    <= wc_s1;
		for (int i = 0; i < 8; i++) begin
			nz_s2[i]  <= |range_s1[8*i +: 8];
			msb_s2[i] <= bfu_pkg::lane_msb(range_s1[8*i +: 8]);
		end
		range_s3 <= range_s2;
		lo_s3    <= lo_s2;
		wc_s3    <= wc_s2;
		zero_s3  <= zero_c;
		nb_s3    <= nb_c;
	end

	assign bnd.valid = v_s3;
	assign bnd.zero  = zero_s3;
	assign bnd.nb    = nb_s3;
	assign bnd.range = range_s3;
	assign bnd.lo    = lo_s3;
	assign bnd.wc    = wc_s3;

endmodule

FILE: rtl/core/bounded_field_bit_unpacker_unit.sv
// Clear, append and unused commands give no item and leave the sequencer idle.
// A field read passes the bound pipeline, then S_READ, S_FIN and S_OUT; C = ceil(bits / 8);
//   a zero range or a short message goes from S_BND straight to S_OUT, which waits for a free output.
// One read at a time: in_stall holds new items off until the sequencer is idle again;
//   the memory read port gives one byte per cycle, C + 1 byte reads per field.
// Reset: arst_n clears length, cursors, sequencer and valids; memory undefined.
// ----------------------------------------------------------------------------
// bounded_field_bit_unpacker_unit
// Loads a byte message and reads range-coded fields from it, low chunk first, each chunk MSB first.
// ----------------------------------------------------------------------------
module bounded_field_bit_unpacker_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  byte_in,
	input  logic [63:0] min_value,
	input  logic [63:0] max_value,
	input  logic [1:0]  width_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] value,
	output logic [1:0]  status
);

	localparam int LEN_W  = bfu_pkg::LEN_W;
	localparam int POS_W  = bfu_pkg::POS_W;
	localparam int ADDR_W = bfu_pkg::ADDR_W;

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_BND  = 3'd1;   // wait for bit count
	localparam logic [2:0] S_READ = 3'd2;   // stream bytes, build chunks
	localparam logic [2:0] S_FIN  = 3'd3;   // range check, add min, advance
	localparam logic [2:0] S_OUT  = 3'd4;   // hand item to output register

	logic [2:0]       state_q;
	logic [LEN_W-1:0] length_q;
	logic [LEN_W-1:0] byte_cur_q;
	logic [2:0]       bit_cur_q;

	// read sequencing
	logic [3:0]  iss_q;       // bytes issued so far
	logic        rv_q;        // read data valid this cycle
	logic        got_q;       // first byte already captured
	logic [2:0]  ck_q;        // chunk being built
	logic [2:0]  last_ck_q;
	logic [3:0]  last_n_q;    // bits in the final chunk

	// field payload
	logic [6:0]  nb_q;
	logic [63:0] range_q;
	logic [63:0] lo_q;
	logic [1:0]  wc_q;
	logic [63:0] acc_q;
	logic [7:0]  prev_q;
	logic [63:0] res_value_q;
	logic [1:0]  res_status_q;

	logic        out_valid_q;
	logic [63:0] out_value_q;
	logic [1:0]  out_status_q;

	bfu_pkg::bnd_t bnd;

	logic             in_take;
	logic             wr_en;
	logic             rd_en;
	logic [LEN_W-1:0] rd_byte;
	logic [7:0]       rd_data;
	logic [POS_W-1:0] pos;
	logic [POS_W-1:0] rem;
	logic             short_c;
	logic [3:0]       nchunk_c;
	logic [3:0]       n_cur;
	logic [15:0]      win16;
	logic [7:0]       win8;
	logic [7:0]       chunk;
	logic             out_free;

	assign in_stall = (state_q != S_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign wr_en    = in_take && (cmd == bfu_pkg::CMD_APPEND)
		&& (length_q < LEN_W'(bfu_pkg::MESSAGE_BYTES));

	// bit position in the message and bits still unread
	assign pos     = {byte_cur_q, bit_cur_q};
	assign rem     = {length_q, 3'b000} - pos;
	assign short_c = rem < POS_W'(bnd.nb);
	assign nchunk_c = 4'((bnd.nb + 7'd7) >> 3);

	// one read per cycle: byte_cursor .. byte_cursor + chunks
	assign rd_en   = (state_q == S_READ) && (iss_q <= {1'b0, last_ck_q} + 4'd1);
	assign rd_byte = byte_cur_q + LEN_W'(iss_q);

	// a chunk is the 8 stream bits at the bit cursor, spanning two bytes;
	// the final chunk keeps only its leading bits, right aligned
	assign n_cur = (ck_q == last_ck_q) ? last_n_q : 4'd8;
	assign win16 = {prev_q, rd_data} << bit_cur_q;
	assign win8  = win16[15:8];
	assign chunk = win8 >> (4'd8 - n_cur);

	assign out_free = !out_valid_q || !out_stall;

	bfu_msg_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (length_q[ADDR_W-1:0]),
		.wr_data (byte_in),
		.rd_en   (rd_en),
		.rd_addr (rd_byte[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	bfu_bound_calc u_bound (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (in_take && (cmd == bfu_pkg::CMD_READ)),
		.min_value  (min_value),
		.max_value  (max_value),
		.width_code (width_code),
		.bnd        (bnd)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			length_q    <= '0;
			byte_cur_q  <= '0;
			bit_cur_q   <= 3'd0;
			iss_q       <= 4'd0;
			rv_q        <= 1'b0;
			got_q       <= 1'b0;
			ck_q        <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			rv_q <= rd_en;
			if (rd_en) begin
				iss_q <= iss_q + 4'd1;
			end
			// the output step reloads the register itself
			if (out_valid_q && !out_stall && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						case (cmd)
							bfu_pkg::CMD_CLEAR: begin
								length_q   <= '0;
								byte_cur_q <= '0;
								bit_cur_q  <= 3'd0;
							end
							bfu_pkg::CMD_APPEND: begin
								if (wr_en) begin
									length_q <= length_q + LEN_W'(1);
								end
							end
							bfu_pkg::CMD_READ: begin
								state_q <= S_BND;
							end
							default: begin
							end
						endcase
					end
				end
				S_BND: begin
					if (bnd.valid) begin
						if (bnd.zero || short_c) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_READ;
							iss_q   <= 4'd0;
							got_q   <= 1'b0;
							ck_q    <= 3'd0;
						end
					end
				end
				S_READ: begin
					if (rv_q) begin
						if (!got_q) begin
							got_q <= 1'b1;
						end else begin
							ck_q <= ck_q + 3'd1;
							if (ck_q == last_ck_q) begin
								state_q <= S_FIN;
							end
						end
					end
				end
				S_FIN: begin
					{byte_cur_q, bit_cur_q} <= pos + POS_W'(nb_q);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_BND: begin
				nb_q      <= bnd.nb;
				range_q   <= bnd.range;
				lo_q      <= bnd.lo;
				wc_q      <= bnd.wc;
				acc_q     <= 64'd0;
				last_ck_q <= 3'(nchunk_c - 4'd1);
				last_n_q  <= (bnd.nb[2:0] == 3'd0) ? 4'd8 : {1'b0, bnd.nb[2:0]};
				res_value_q <= 64'd0;
				if (bnd.zero) begin
					res_status_q <= bfu_pkg::ST_BOUNDS;
				end else begin
					res_status_q <= bfu_pkg::ST_SHORT;
				end
			end
			S_READ: begin
				if (rv_q) begin
					prev_q <= rd_data;
					if (got_q) begin
						acc_q[{ck_q, 3'b000} +: 8] <= chunk;
					end
				end
			end
			S_FIN: begin
				if (acc_q > range_q) begin
					res_value_q  <= 64'd0;
					res_status_q <= bfu_pkg::ST_ABOVE;
				end else begin
					res_value_q  <= (acc_q + lo_q) & bfu_pkg::width_mask(wc_q);
					res_status_q <= bfu_pkg::ST_OK;
				end
			end
			S_OUT: begin
				if (out_free) begin
					out_value_q  <= res_value_q;
					out_status_q <= res_status_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign value     = out_value_q;
	assign status    = out_status_q;

	// cursor never passes the end of the loaded message
	a_cursor_in_msg: assert property (@(posedge clk) disable iff (!arst_n)
		pos <= {length_q, 3'b000})
		else $error("bit cursor beyond message length");

	a_length_cap: assert property (@(posedge clk) disable iff (!arst_n)
		length_q <= LEN_W'(bfu_pkg::MESSAGE_BYTES))
		else $error("message length above capacity");

	a_chunk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> (ck_q <= last_ck_q))
		else $error("chunk index past final chunk");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q != bfu_pkg::ST_OK)) |-> (out_value_q == 64'd0))
		else $error("error item carries nonzero value");

	a_fin_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> ($past(state_q) == S_READ && !rv_q))
		else $error("finish reached without completed byte stream");

endmodule

FILE: sim/tb_bounded_field_bit_unpacker_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_field_bit_unpacker_unit
// Self-checking bench for the bounded field unpacker. A table of directed
// items runs first, then a full-message fill, then random message loads and
// field reads. Every read is predicted in the bench and each result item is
// compared in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_bounded_field_bit_unpacker_unit;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_ITEMS = 800;
	localparam int QUIET_TAIL   = 150;      // last items run with no idling
	localparam int DRAIN_CYCLES = 40;       // extra clocks after the final drain
	localparam int LIMIT_NS     = 10000000; // watchdog limit, in ns

	// codes the package leaves unnamed
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [1:0] WC_64      = 2'd3;

	// one input item, plus a typed-in result where it is obvious
	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  data;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [1:0]  wc;
		logic        typed;
		logic [63:0] exp_value;
		logic [1:0]  exp_status;
	} stim_row_t;

	typedef struct packed {
		logic [63:0] value;
		logic [1:0]  status;
	} field_result_t;

	localparam int NUM_DIR = 25;
	localparam stim_row_t DIR_ROWS [NUM_DIR] = '{
		// read right after reset: nothing loaded
		'{bfu_pkg::CMD_READ, 8'h00, 64'h0, 64'h1, bfu_pkg::WC_8,
			1'b1, 64'h0, bfu_pkg::ST_SHORT},
		// equal bounds
		'{bfu_pkg::CMD_READ, 8'h00, 64'h5, 64'h5, bfu_pkg::WC_16,
			1'b1, 64'h0, bfu_pkg::ST_BOUNDS},
		// bounds differ only above the width
		'{bfu_pkg::CMD_READ, 8'h00, 64'h1FF, 64'h0FF, bfu_pkg::WC_8,
			1'b1, 64'h0, bfu_pkg::ST_BOUNDS},
		// unused command, all ones elsewhere
		'{CMD_UNUSED, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, WC_64,
			1'b0, 64'h0, bfu_pkg::ST_OK},
		'{bfu_pkg::CMD_APPEND, 8'hFF, 64'h0, 64'h0, bfu_pkg::WC_8,
			1'b0, 64'h0, bfu_pkg::ST_OK},
		'{bfu_pkg::CMD_APPEND, 8'h00, 64'h0, 64'h0, bfu_pkg::WC_8,
			1'b0, 64'h0, bfu_pkg::ST_OK},
		// full byte of ones
		'{bfu_pkg::CMD_READ, 8'h00, 64'h0, 64'hFF, bfu_pkg::WC_8,
			1'b1, 64'hFF, bfu_pkg::ST_OK},
		// seven bits from the zero byte
		'{bfu_pkg::CMD_READ, 8'h00, 64'h0, 64'h7F, bfu_pkg::WC_8,
			1'b0, 64'h0, bfu_pkg::ST_OK},
		// two bits wanted, one left
		'{bfu_pkg::CMD_READ, 8'h00, 64'h0, 64'h3, bfu_pkg::WC_8,
			1'b1, 64'h0, bfu_pkg::ST_SHORT},
		// last bit, offset by min
		'{bfu_pkg::CMD_READ, 8'h00, 64'd10, 64'd11, bfu_pkg::WC_8,
			1'b0, 64'h0, bfu_pkg::ST_OK},
		'{bfu_pkg::CMD_APPEND, 8'hFF, 64'h0, 64'h0, bfu_pkg::WC_8,
			1'b0, 64'h0, bfu_pkg::ST_OK},
		// 0xFF above range 0x80
		'{bfu_pkg::CMD_READ, 8'h00, 64'h0, 64'h80, bfu_pkg::WC_8,
			1'b1, 64'h0, bfu_pkg::ST_ABOVE},
		'{bfu_pkg::CMD_APPEND, 8'h80, 64'h0, 64'h0, bfu_pkg::WC_8,
			1'b0, 64'h0, bfu_pkg::ST_OK},
		'{bfu_pkg::CMD_APPEND, 8'h01, 64'h0, 64'h0, bfu_pkg::WC_8,
			1'b0, 64'h0, bfu_pkg::ST_OK},
		'{bfu_pkg::CMD_APPEND, 8'hC3, 64'h0, 64'h0, bfu_pkg::WC_8,
			1'b0, 64'h0, bfu_pkg::ST_OK},
		'{bfu_pkg::CMD_APPEND, 8'h3C, 64'h0, 64'h0, bfu_pkg::WC_8,
			1'b0, 64'h0, bfu_pkg::ST_OK},
		'{bfu_pkg::CMD_APPEND, 8'h7E, 64'h0, 64'h0, bfu_pkg::WC_8,
			1'b0, 64'h0, bfu_pkg::ST_OK},
		'{bfu_pkg::CMD_APPEND, 8'hE7, 64'h0, 64'h0, bfu_pkg::WC_8,
			1'b0, 64'h0, bfu_pkg::ST_OK},
		'{bfu_pkg::CMD_APPEND, 8'h55, 64'h0, 64'h0, bfu_pkg::WC_8,
			1'b0, 64'h0, bfu_pkg::ST_OK},
		'{bfu_pkg::CMD_APPEND, 8'hAA, 64'h0, 64'h0, bfu_pkg::WC_8,
			1'b0, 64'h0, bfu_pkg::ST_OK},
		// full 64-bit range, exactly the bits left, min wraps the sum
		'{bfu_pkg::CMD_READ, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
			WC_64, 1'b0, 64'h0, bfu_pkg::ST_OK},
		'{bfu_pkg::CMD_CLEAR, 8'hA5, 64'h0, 64'h0, bfu_pkg::WC_8,
			1'b0, 64'h0, bfu_pkg::ST_OK},
		'{bfu_pkg::CMD_READ, 8'h00, 64'h0, 64'hFFFF_FFFF, bfu_pkg::WC_32,
			1'b1, 64'h0, bfu_pkg::ST_SHORT},
		'{bfu_pkg::CMD_APPEND, 8'hF0, 64'h0, 64'h0, bfu_pkg::WC_8,
			1'b0, 64'h0, bfu_pkg::ST_OK},
		// min with junk above the width, range 2, bits 11 -> above
		'{bfu_pkg::CMD_READ, 8'h00, 64'hFFFF_FFFF_FFFF_0003, 64'h5, bfu_pkg::WC_16,
			1'b0, 64'h0, bfu_pkg::ST_OK}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  cmd;
	logic [7:0]  byte_in;
	logic [63:0] min_value;
	logic [63:0] max_value;
	logic [1:0]  width_code;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] value;
	logic [1:0]  status;

	bounded_field_bit_unpacker_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.byte_in    (byte_in),
		.min_value  (min_value),
		.max_value  (max_value),
		.width_code (width_code),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value      (value),
		.status     (status)
	);

	// bench copy of the message and read position
	logic [7:0]  msg_bytes [bfu_pkg::MESSAGE_BYTES];
	int unsigned msg_len;
	int unsigned cur_byte;
	int unsigned cur_bit;

	field_result_t pending_fields [$];
	int            errors;
	bit            quiet;   // end of run: no idling on either side
	bit            calm;    // per-phase stretch with no idling

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [63:0] ones(input int n);
		return (n >= 64) ? {64{1'b1}} : ((64'd1 << n) - 64'd1);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Updates the bench message state for one item; returns 1 when the item
	// yields a result, which is then in r.
	function automatic bit decode_item(input stim_row_t row, output field_result_t r);
		logic [63:0]     mask;
		logic [63:0]     lo;
		logic [63:0]     span;
		logic [63:0]     acc;
		logic [63:0]     chunk;
		int              nb;
		int              taken;
		int              n;
		int              chunk_idx;
		longint unsigned used;
		longint unsigned avail;

		r = '0;
		case (row.op)
			bfu_pkg::CMD_CLEAR: begin
				msg_len  = 0;
				cur_byte = 0;
				cur_bit  = 0;
				return 1'b0;
			end
			bfu_pkg::CMD_APPEND: begin
				// a full message drops further bytes
				if (msg_len < bfu_pkg::MESSAGE_BYTES) begin
					msg_bytes[msg_len] = row.data;
					msg_len++;
				end
				return 1'b0;
			end
			bfu_pkg::CMD_READ: begin
			end
			default: begin
				return 1'b0;
			end
		endcase

		mask = ones(8 << row.wc);
		lo   = row.lo & mask;
		span = ((row.hi & mask) - lo) & mask;
		if (span == 64'd0) begin
			r.status = bfu_pkg::ST_BOUNDS;
			return 1'b1;
		end

		nb = 0;
		for (int k = 0; k < 64; k++) begin
			if (span[k]) begin
				nb = k + 1;
			end
		end

		// short message: cursor stays put
		used  = longint'(cur_byte) * 8 + cur_bit;
		avail = longint'(msg_len) * 8;
		avail = (avail > used) ? avail - used : 0;
		if (avail < nb) begin
			r.status = bfu_pkg::ST_SHORT;
			return 1'b1;
		end

		// chunks of up to 8 bits fill the value from the low byte up,
		// each chunk MSB first out of the message
		acc       = '0;
		taken     = 0;
		chunk_idx = 0;
		while (taken < nb) begin
			n = (nb - taken > 8) ? 8 : nb - taken;
			chunk = '0;
			for (int k = 0; k < n; k++) begin
				chunk = (chunk << 1) | 64'(msg_bytes[cur_byte][7 - cur_bit]);
				cur_bit++;
				if (cur_bit == 8) begin
					cur_bit = 0;
					cur_byte++;
				end
			end
			acc |= chunk << (8 * chunk_idx);
			chunk_idx++;
			taken += n;
		end

		if (acc > span) begin
			r.status = bfu_pkg::ST_ABOVE;
			return 1'b1;
		end
		r.value  = (acc + lo) & mask;
		r.status = bfu_pkg::ST_OK;
		return 1'b1;
	endfunction

	// Random read: mostly well-formed bounds whose range has a chosen bit
	// length, with some zero ranges and some fully random bounds.
	function automatic stim_row_t random_read();
		stim_row_t row;
		int        w;
		int        nb;
		int        sel;
		logic [63:0] span;

		row      = '0;
		row.op   = bfu_pkg::CMD_READ;
		row.data = 8'($urandom_range(0, 255));
		row.wc   = 2'($urandom_range(0, 3));
		row.lo   = rand64();
		w        = 8 << row.wc;
		sel      = $urandom_range(0, 15);
		if (sel == 0) begin
			// equal in the low W bits, random above
			row.hi = row.lo ^ (rand64() & ~ones(w));
		end else if (sel == 1) begin
			row.hi = rand64();
		end else begin
			// favor short fields so several reads fit a small message
			nb = $urandom_range(0, 1) ? $urandom_range(1, (w < 12) ? w : 12)
			                          : $urandom_range(1, w);
			span = (rand64() & ones(nb)) | (64'd1 << (nb - 1));
			// junk above the width must not matter
			row.hi = (row.lo + span) ^ (rand64() & ~ones(w));
		end
		return row;
	endfunction

	function automatic stim_row_t random_append();
		stim_row_t row;
		row      = '0;
		row.op   = bfu_pkg::CMD_APPEND;
		row.data = 8'($urandom_range(0, 255));
		row.lo   = rand64();
		row.hi   = rand64();
		row.wc   = 2'($urandom_range(0, 3));
		return row;
	endfunction

	// Drives one item, holds it through stall, predicts at acceptance.
	task automatic send_item(input stim_row_t row);
		field_result_t r;
		int            gap;

		if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= row.op;
		byte_in    <= row.data;
		min_value  <= row.lo;
		max_value  <= row.hi;
		width_code <= row.wc;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (decode_item(row, r)) begin
			if (row.typed) begin
				r.value  = row.exp_value;
				r.status = row.exp_status;
			end
			pending_fields.push_back(r);
		end
	endtask

	// Sender holds off until every predicted result has come back.
	task automatic drain_fields();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_fields.size() != 0) @(posedge clk);
	endtask

	// receiver: random stall bursts between open stretches
	initial begin : stall_gen
		int len;
		out_stall = 1'b0;
		forever begin
			if (quiet || calm) begin
				out_stall <= 1'b0;
				len = 1;
			end else if ($urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				len = $urandom_range(1, 19);
			end else begin
				out_stall <= 1'b0;
				len = $urandom_range(1, 40);
			end
			repeat (len) @(posedge clk);
		end
	end

	// result check, in order against the oldest prediction
	always @(posedge clk) begin : result_check
		field_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_fields.size() == 0) begin
				errors++;
				$display("%0t: result with none expected: value=%h status=%0d",
					$time, value, status);
			end else begin
				want = pending_fields.pop_front();
				if (value !== want.value) begin
					errors++;
					$display("%0t: value mismatch: expected %h, got %h",
						$time, want.value, value);
				end
				if (status !== want.status) begin
					errors++;
					$display("%0t: status mismatch: expected %0d, got %0d",
						$time, want.status, status);
				end
			end
		end
	end

	// main stimulus
	initial begin : stimulus
		stim_row_t row;
		int        sent;
		int        nbytes;
		int        nreads;

		in_valid   = 1'b0;
		cmd        = bfu_pkg::CMD_CLEAR;
		byte_in    = '0;
		min_value  = '0;
		max_value  = '0;
		width_code = bfu_pkg::WC_8;
		arst_n     = 1'b0;
		errors     = 0;
		quiet      = 1'b0;
		calm       = 1'b0;
		msg_len    = 0;
		cur_byte   = 0;
		cur_bit    = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < NUM_DIR; i++) begin
			send_item(DIR_ROWS[i]);
		end

		// fill the whole message, overflow it, then read it out 64 bits at a
		// time until it runs short; this also writes every store entry
		row    = '0;
		row.op = bfu_pkg::CMD_CLEAR;
		send_item(row);
		repeat (bfu_pkg::MESSAGE_BYTES + 4) send_item(random_append());
		repeat (bfu_pkg::MESSAGE_BYTES / 8 + 1) begin
			row    = random_read();
			row.wc = WC_64;
			row.hi = row.lo - 64'd1;
			send_item(row);
		end
		drain_fields();

		// random phases: optional clear, a burst of bytes, then reads
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			quiet = (sent > RANDOM_ITEMS - QUIET_TAIL);
			calm  = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 3) != 0) begin
				row      = random_append();
				row.op   = bfu_pkg::CMD_CLEAR;
				send_item(row);
				sent++;
			end
			nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 64)
			                                     : $urandom_range(1, 24);
			repeat (nbytes) begin
				send_item(random_append());
				sent++;
			end
			nreads = $urandom_range(1, 12);
			repeat (nreads) begin
				// noise: unused command or a late byte between reads
				if ($urandom_range(0, 19) == 0) begin
					row    = random_append();
					row.op = CMD_UNUSED;
					send_item(row);
				end else if ($urandom_range(0, 7) == 0) begin
					send_item(random_append());
					sent++;
				end
				send_item(random_read());
				sent++;
			end
			if (!quiet && $urandom_range(0, 11) == 0) begin
				drain_fields();
			end
		end

		drain_fields();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(LIMIT_NS);
		$display("timeout: %0d results still pending", pending_fields.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: bounded_field_bit_unpacker_unit.f
rtl/core/bfu_pkg.sv
rtl/core/bfu_msg_store.sv
rtl/core/bfu_bound_calc.sv
rtl/core/bounded_field_bit_unpacker_unit.sv
sim/tb_bounded_field_bit_unpacker_unit.sv
